### rtl/core/framed_byte_receive_fifo_macros.svh
// Assertion macros used by the checker file.
// Each macro expects clk and arst_n in scope.
`ifndef FRAMED_BYTE_RECEIVE_FIFO_MACROS_SVH
`define FRAMED_BYTE_RECEIVE_FIFO_MACROS_SVH

// Consequent in the same cycle as the antecedent.
`define FDRX_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent in the cycle after the antecedent.
`define FDRX_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/fdrx_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdrx_pkg
// Types, codes and sizes shared by the framed byte receive FIFO.
// ----------------------------------------------------------------------------
package fdrx_pkg;

	localparam int FIFO_DEPTH = 64;
	localparam int IDX_W      = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int CNT_W      = IDX_W + 1;
	localparam int WAIT_W     = 6;

	// command codes
	localparam logic [1:0] CMD_BYTE = 2'd0;
	localparam logic [1:0] CMD_DEQ  = 2'd1;
	localparam logic [1:0] CMD_CLR  = 2'd2;

	// deframer states; 1..0xFB count payload bytes left
	localparam logic [7:0] START_BYTE = 8'hBF;
	localparam logic [7:0] ST_HUNT    = 8'hFF;
	localparam logic [7:0] ST_LINK    = 8'hFE;
	localparam logic [7:0] ST_FLAGS   = 8'hFD;
	localparam logic [7:0] ST_LENGTH  = 8'hFC;
	localparam logic [7:0] ST_TRAILER = 8'h00;

	typedef struct packed {
		logic [1:0] cmd;
		logic [7:0] line_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0]        read_byte;
		logic              read_valid;
		logic [WAIT_W-1:0] bytes_waiting;
	} out_item_t;

	typedef struct packed {
		logic       push;
		logic       pop;
		logic       clear;
		logic [7:0] wdata;
	} ring_ctl_t;

	typedef struct packed {
		logic              pop_ok;
		logic [WAIT_W-1:0] count_next;
	} ring_sts_t;

endpackage

### rtl/core/framed_byte_receive_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// framed_byte_receive_fifo
// Receive FIFO for serial line bytes with an optional frame stripper.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive item (cmd, line_byte) with start high; the
//   transaction is taken at a clock edge where busy is low. cmd selects
//   store a line byte, dequeue one byte, or clear the FIFO.
//   Result channel: done pulses for one cycle, in the cycle after each
//   accepted command, with read_byte, read_valid and bytes_waiting.
//   busy stays low: a command may be issued every cycle. read_byte comes
//   from the registered read port of the byte store.
//   The receiver cannot stall; each result is on the ports for one cycle.
//   cfg_we/cfg_wdata set framed mode; write it only while no command is
//   pending. In framed mode header and trailer bytes are stripped.
//   Usable capacity is FIFO_DEPTH - 1 bytes; extra bytes are dropped.
//   Reset: FIFO empty, unframed mode, deframer hunting for the start byte.
//   Store contents are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module framed_byte_receive_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  fdrx_pkg::in_item_t  item,
	output logic                done,
	output fdrx_pkg::out_item_t result,
	input  logic                cfg_we,
	input  logic                cfg_wdata
);
	import fdrx_pkg::*;

	logic              accept, is_byte, dfr_take;
	logic              framed_q, done_q, valid_q;
	logic [WAIT_W-1:0] count_q;
	logic [7:0]        rdata_s1;
	ring_ctl_t         ctl;
	ring_sts_t         sts;

	assign busy    = 1'b0;
	assign accept  = start && !busy;
	assign is_byte = accept && (item.cmd == CMD_BYTE);

	fdrx_deframer u_dfr (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (is_byte && framed_q),
		.line_byte (item.line_byte),
		.take      (dfr_take)
	);

	assign ctl.push  = is_byte && (!framed_q || dfr_take);
	assign ctl.pop   = accept && (item.cmd == CMD_DEQ);
	assign ctl.clear = accept && (item.cmd == CMD_CLR);
	assign ctl.wdata = item.line_byte;

	fdrx_ring u_ring (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.sts      (sts),
		.rdata_s1 (rdata_s1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			framed_q <= 1'b0;
			done_q   <= 1'b0;
			valid_q  <= 1'b0;
		end else begin
			if (cfg_we) framed_q <= cfg_wdata;
			done_q  <= accept;
			valid_q <= sts.pop_ok;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) count_q <= sts.count_next;
	end

	assign done                 = done_q;
	assign result.read_byte     = valid_q ? rdata_s1 : 8'd0;
	assign result.read_valid    = valid_q;
	assign result.bytes_waiting = count_q;

endmodule

### rtl/core/fdrx_deframer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdrx_deframer
// Frame header/trailer stripper. Tracks the frame position and flags the
// bytes that belong to the payload.
// ----------------------------------------------------------------------------
module fdrx_deframer (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       en,
	input  logic [7:0] line_byte,
	output logic       take
);
	import fdrx_pkg::*;

	logic [7:0] frame_q;
	logic [7:0] frame_d;

	always_comb begin
		frame_d = frame_q;
		take    = 1'b0;
		unique case (frame_q)
			ST_HUNT: begin
				if (line_byte == START_BYTE) frame_d = ST_LINK;
			end
			ST_LINK:    frame_d = ST_FLAGS;
			ST_FLAGS:   frame_d = ST_LENGTH;
			ST_LENGTH:  frame_d = line_byte;
			ST_TRAILER: frame_d = ST_HUNT;
			default: begin
				frame_d = frame_q - 8'd1;
				take    = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_q <= ST_HUNT;
		end else if (en) begin
			frame_q <= frame_d;
		end
	end

endmodule

### rtl/core/fdrx_ring.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdrx_ring
// Ring buffer: byte store with registered read, write/read indices and the
// fill count after each transaction.
// ----------------------------------------------------------------------------
module fdrx_ring (
	input  logic                 clk,
	input  logic                 arst_n,
	input  fdrx_pkg::ring_ctl_t  ctl,
	output fdrx_pkg::ring_sts_t  sts,
	output logic [7:0]           rdata_s1
);
	import fdrx_pkg::*;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FIFO_DEPTH - 1);

	logic [7:0]       mem [FIFO_DEPTH];
	logic [IDX_W-1:0] wr_q, rd_q;
	logic [IDX_W-1:0] wr_inc, rd_inc, wr_d, rd_d;
	logic             full, empty, do_push, do_pop;
	logic [CNT_W-1:0] cnt;

	assign wr_inc  = (wr_q == LAST_IDX) ? '0 : wr_q + 1'b1;
	assign rd_inc  = (rd_q == LAST_IDX) ? '0 : rd_q + 1'b1;
	assign full    = (wr_inc == rd_q);
	assign empty   = (wr_q == rd_q);
	assign do_push = ctl.push && !full;
	assign do_pop  = ctl.pop && !empty;

	always_comb begin
		wr_d = wr_q;
		rd_d = rd_q;
		if (ctl.clear) begin
			wr_d = '0;
			rd_d = '0;
		end else begin
			if (do_push) wr_d = wr_inc;
			if (do_pop)  rd_d = rd_inc;
		end
	end

	always_comb begin
		if (wr_d >= rd_d) cnt = CNT_W'(wr_d) - CNT_W'(rd_d);
		else              cnt = CNT_W'(FIFO_DEPTH) + CNT_W'(wr_d) - CNT_W'(rd_d);
	end

	assign sts.pop_ok     = do_pop;
	assign sts.count_next = WAIT_W'(cnt);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
		end else begin
			wr_q <= wr_d;
			rd_q <= rd_d;
		end
	end

	// entries are written before they can be read, so no bypass is needed
	always_ff @(posedge clk) begin
		if (do_push) mem[wr_q] <= ctl.wdata;
		rdata_s1 <= mem[rd_q];
	end

endmodule

### rtl/core/fdrx_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdrx_checker
// Port-level checks for the framed byte receive FIFO, bound to the top level.
// ----------------------------------------------------------------------------
`include "framed_byte_receive_fifo_macros.svh"

module fdrx_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                start,
	input logic                busy,
	input fdrx_pkg::in_item_t  item,
	input logic                done,
	input fdrx_pkg::out_item_t result
);
	import fdrx_pkg::*;

	// every accepted transaction gets a result in the next cycle
	`FDRX_ASSERT_NEXT(a_done_follows, start && !busy, done, "missing result strobe")

	// no result without a transaction before it
	`FDRX_ASSERT_SAME(a_no_spurious, done, $past(start && !busy), "result with no transaction")

	// only a dequeue can deliver a byte
	`FDRX_ASSERT_NEXT(a_valid_deq, start && !busy && item.cmd != CMD_DEQ,
		!result.read_valid, "byte delivered for a non-dequeue command")

	// a clear empties the FIFO
	`FDRX_ASSERT_NEXT(a_clear_empty, start && !busy && item.cmd == CMD_CLR,
		result.bytes_waiting == '0, "FIFO not empty after clear")

	// nothing read means zero data
	`FDRX_ASSERT_SAME(a_zero_byte, done && !result.read_valid,
		result.read_byte == 8'd0, "nonzero byte without valid")

endmodule

bind framed_byte_receive_fifo fdrx_checker u_fdrx_checker (.*);

### verif/tb_framed_byte_receive_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_framed_byte_receive_fifo
// Self-checking bench for the framed byte receive FIFO. Line bytes, dequeues,
// clears and the idle command are driven in both unframed and framed mode.
// An in-bench ring and deframer predict every result. Each strobed result is
// compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_framed_byte_receive_fifo;
	import fdrx_pkg::*;

	localparam logic [1:0] CMD_NONE    = 2'd3;
	localparam int         ITEMS_TOTAL = 950;
	localparam int         CYCLE_LIMIT = 400000;

	logic      clk;
	logic      arst_n;
	logic      start;
	logic      busy;
	in_item_t  item;
	logic      done;
	out_item_t result;
	logic      cfg_we;
	logic      cfg_wdata;

	// predicted block state
	logic       framed_mode_q = 1'b0;
	logic [7:0] deframe_state = ST_HUNT;
	logic [7:0] ring_mem [FIFO_DEPTH];
	int         wr_ptr = 0;
	int         rd_ptr = 0;

	out_item_t fifo_results_due [$];
	int        error_count = 0;
	int        cycle_count = 0;
	int        sent_items  = 0;
	int        gap_ceiling = 13;
	int        read_pct    = 50;

	framed_byte_receive_fifo u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.item     (item),
		.done     (done),
		.result   (result),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch at cycle %0d: %s got %0h want %0h", cycle_count, what, got, want);
		error_count++;
	endtask

	// bytes that would make the write pointer meet the read pointer are dropped
	task automatic ring_push(input logic [7:0] b);
		int nxt;
		nxt = (wr_ptr + 1 >= FIFO_DEPTH) ? 0 : wr_ptr + 1;
		if (nxt != rd_ptr) begin
			ring_mem[wr_ptr] = b;
			wr_ptr = nxt;
		end
	endtask

	task automatic predict_fifo_result(input in_item_t it, output out_item_t res);
		int waiting;
		res = '0;
		case (it.cmd)
			CMD_BYTE: begin
				if (!framed_mode_q) begin
					ring_push(it.line_byte);
				end else begin
					case (deframe_state)
						ST_HUNT: if (it.line_byte == START_BYTE) deframe_state = ST_LINK;
						ST_LINK: deframe_state = ST_FLAGS;
						ST_FLAGS: deframe_state = ST_LENGTH;
						ST_LENGTH: deframe_state = it.line_byte;
						ST_TRAILER: deframe_state = ST_HUNT;
						default: begin
							// payload count runs down even when the byte is dropped
							deframe_state = deframe_state - 8'd1;
							ring_push(it.line_byte);
						end
					endcase
				end
			end
			CMD_DEQ: begin
				if (wr_ptr != rd_ptr) begin
					res.read_byte  = ring_mem[rd_ptr];
					res.read_valid = 1'b1;
					rd_ptr = (rd_ptr + 1 >= FIFO_DEPTH) ? 0 : rd_ptr + 1;
				end
			end
			CMD_CLR: begin
				wr_ptr = 0;
				rd_ptr = 0;
			end
			default: ;
		endcase
		waiting = (wr_ptr >= rd_ptr) ? wr_ptr - rd_ptr : FIFO_DEPTH + wr_ptr - rd_ptr;
		res.bytes_waiting = WAIT_W'(waiting);
	endtask

	// check the strobed result before queueing the transaction taken at this edge
	always @(posedge clk) begin : result_check
		out_item_t due;
		out_item_t fresh;
		cycle_count++;
		if (arst_n) begin
			if (done) begin
				if (fifo_results_due.size() == 0) begin
					report_mismatch("result with nothing pending", 32'(result), '0);
				end else begin
					due = fifo_results_due.pop_front();
					if (result.read_byte !== due.read_byte)
						report_mismatch("read_byte", 32'(result.read_byte),
							32'(due.read_byte));
					if (result.read_valid !== due.read_valid)
						report_mismatch("read_valid", 32'(result.read_valid),
							32'(due.read_valid));
					if (result.bytes_waiting !== due.bytes_waiting)
						report_mismatch("bytes_waiting", 32'(result.bytes_waiting),
							32'(due.bytes_waiting));
				end
			end
			if (start && !busy) begin
				predict_fifo_result(item, fresh);
				fifo_results_due.push_back(fresh);
			end
			if (cfg_we) framed_mode_q = cfg_wdata;
		end
	end

	task automatic send_cmd(input logic [1:0] c, input logic [7:0] b);
		int gap;
		gap = $urandom_range(gap_ceiling, 0);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item  <= '{cmd: c, line_byte: b};
		start <= 1'b1;
		do @(posedge clk); while (busy);
		sent_items++;
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		@(posedge clk);
		while (fifo_results_due.size() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic set_framed_mode(input logic m);
		wait_drained();
		cfg_we    <= 1'b1;
		cfg_wdata <= m;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic shuffle_pace();
		int pick;
		gap_ceiling = ($urandom_range(3, 0) == 0) ? 0 : 13;
		pick = $urandom_range(2, 0);
		read_pct = (pick == 0) ? 25 : (pick == 1) ? 50 : 75;
	endtask

	// a line byte with random dequeues, clears and idle commands ahead of it
	task automatic send_with_reads(input logic [7:0] b);
		int r;
		while ($urandom_range(99, 0) < read_pct) send_cmd(CMD_DEQ, 8'($urandom()));
		r = $urandom_range(99, 0);
		if (r < 2) send_cmd(CMD_CLR, 8'($urandom()));
		else if (r < 5) send_cmd(CMD_NONE, 8'($urandom()));
		send_cmd(CMD_BYTE, b);
	endtask

	task automatic test_unframed_edges();
		set_framed_mode(1'b0);
		send_cmd(CMD_DEQ, 8'h00);
		send_cmd(CMD_BYTE, 8'h00);
		send_cmd(CMD_BYTE, 8'hFF);
		send_cmd(CMD_NONE, 8'hFF);
		send_cmd(CMD_DEQ, 8'h00);
		send_cmd(CMD_CLR, 8'h00);
		send_cmd(CMD_DEQ, 8'h00);
	endtask

	task automatic test_framed_edges();
		set_framed_mode(1'b1);
		// two-byte payload
		send_cmd(CMD_BYTE, START_BYTE);
		send_cmd(CMD_BYTE, 8'h00);
		send_cmd(CMD_BYTE, 8'hFF);
		send_cmd(CMD_BYTE, 8'h02);
		send_cmd(CMD_BYTE, 8'h11);
		send_cmd(CMD_BYTE, 8'hEE);
		send_cmd(CMD_BYTE, 8'h77);
		// zero length: next byte is the trailer
		send_cmd(CMD_BYTE, START_BYTE);
		send_cmd(CMD_BYTE, 8'h01);
		send_cmd(CMD_BYTE, 8'h02);
		send_cmd(CMD_BYTE, 8'h00);
		send_cmd(CMD_BYTE, 8'h99);
		// length that names a header step sends the deframer back to it
		send_cmd(CMD_BYTE, START_BYTE);
		send_cmd(CMD_BYTE, 8'h03);
		send_cmd(CMD_BYTE, 8'h04);
		send_cmd(CMD_BYTE, ST_LINK);
		send_cmd(CMD_BYTE, 8'h05);
		send_cmd(CMD_BYTE, 8'h06);
		send_cmd(CMD_BYTE, 8'h01);
		send_cmd(CMD_BYTE, 8'h5A);
		send_cmd(CMD_BYTE, 8'h7B);
		repeat (4) send_cmd(CMD_DEQ, 8'h00);
	endtask

	task automatic test_fifo_fill();
		set_framed_mode(1'b0);
		gap_ceiling = 0;
		repeat (FIFO_DEPTH + 6) send_cmd(CMD_BYTE, 8'($urandom()));
		gap_ceiling = 13;
		repeat (FIFO_DEPTH + 2) send_cmd(CMD_DEQ, 8'($urandom()));
	endtask

	task automatic test_random_unframed();
		set_framed_mode(1'b0);
		for (int i = 0; i < 250; i++) begin
			if (i % 40 == 0) shuffle_pace();
			send_with_reads(8'($urandom()));
		end
	endtask

	task automatic test_random_framed();
		logic [7:0] frame_bytes [$];
		logic [7:0] len;
		int         r;
		int         body;
		set_framed_mode(1'b1);
		while (sent_items < ITEMS_TOTAL) begin
			shuffle_pace();
			// unframed stretch; deframer state must survive it
			if ($urandom_range(7, 0) == 0) begin
				set_framed_mode(1'b0);
				repeat ($urandom_range(20, 5)) send_with_reads(8'($urandom()));
				set_framed_mode(1'b1);
			end
			if ($urandom_range(4, 0) == 0)
				repeat ($urandom_range(3, 1)) send_with_reads(8'($urandom()));
			r = $urandom_range(99, 0);
			if (r < 80) len = 8'($urandom_range(12, 0));
			else if (r < 92) len = 8'($urandom_range(80, 13));
			else if (r < 94) len = 8'($urandom_range(8'hFB, 81));
			else len = 8'($urandom_range(8'hFF, 8'hFC));
			body = (len <= 8'hFB) ? int'(len) : int'($urandom_range(6, 0));
			frame_bytes = {START_BYTE, 8'($urandom()), 8'($urandom()), len};
			repeat (body + 1) frame_bytes.push_back(8'($urandom()));
			// broken frame: cut short anywhere
			if ($urandom_range(9, 0) == 0)
				while (frame_bytes.size() > $urandom_range(frame_bytes.size(), 1))
					void'(frame_bytes.pop_back());
			foreach (frame_bytes[k]) send_with_reads(frame_bytes[k]);
		end
	endtask

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		arst_n    <= 1'b0;
		start     <= 1'b0;
		item      <= '0;
		cfg_we    <= 1'b0;
		cfg_wdata <= 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_unframed_edges();
		test_framed_edges();
		test_fifo_fill();
		test_random_unframed();
		test_random_framed();
		wait_drained();
		if (error_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
